[rtl/galm_pkg.sv]
package galm_pkg;

  localparam int unsigned NumLocksDefault   = 16;
  localparam int unsigned QueueDepthDefault = 16;

  localparam logic [31:0] LcgMul  = 32'd1664525;
  localparam logic [31:0] LcgAdd  = 32'd1013904223;
  localparam logic [31:0] SeedRst = 32'd1;

  // floor(2^32 / 100): quotient estimate is exact or one low
  localparam logic [25:0] RecipDiv100 = 26'd42949672;
  localparam logic [7:0]  DrawMod     = 8'd100;

  localparam logic [1:0] OpCreate  = 2'd0;
  localparam logic [1:0] OpAcquire = 2'd1;
  localparam logic [1:0] OpRelease = 2'd2;
  localparam logic [1:0] OpDestroy = 2'd3;

  localparam logic [1:0] KindReply = 2'd0;
  localparam logic [1:0] KindGrant = 2'd1;
  localparam logic [1:0] KindFail  = 2'd2;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StBadArg   = 3'd1;
  localparam logic [2:0] StInactive = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StNotHeld  = 3'd4;
  localparam logic [2:0] StQueued   = 3'd5;

  localparam logic [6:0] FavorMax = 7'd100;

  localparam logic [1:0] RegSeed = 2'd0;

  // controller to datapath
  typedef struct packed {
    logic latch;      // capture request fields
    logic cre_do;     // commit create
    logic acq_grant;  // mark held
    logic acq_queue;  // append waiter
    logic rel_clear;  // clear held
    logic scan_step;  // advance queue pointer
    logic scan_init;  // reset pointer and pick
    logic lcg_step;   // advance generator
    logic lcg_mod;    // register quotient estimate
    logic lcg_pick;   // reduce draw and pick the matching waiter
    logic rd_issue;   // issue memory read at pointer
    logic shift_init; // move pointer to the picked entry
    logic head_cap;   // capture the granted entry
    logic shift_step; // move one entry down
    logic rel_finish; // commit release
    logic des_do;     // deactivate
    logic emit_reply;
    logic emit_grant;
    logic emit_fail;
    logic [2:0] status;
  } galm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       fav_bad;
    logic       none_free;
    logic       idx_bad;
    logic       active;
    logic       held;
    logic       q_empty;
    logic       q_full;
    logic       scan_end;
    logic       grp_hit;
    logic       out_busy;
  } galm_sts_t;

endpackage

[rtl/galm_datapath.sv]
module galm_datapath import galm_pkg::*; #(
  parameter int unsigned NUM_LOCKS   = NumLocksDefault,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  op_i,
  input  logic [3:0]  lock_index_i,
  input  logic [7:0]  requester_tag_i,
  input  logic [15:0] requester_group_i,
  input  logic [6:0]  favor_percent_i,
  input  logic        seed_we_i,
  input  logic [31:0] seed_i,
  input  galm_cmd_t   cmd_i,
  output galm_sts_t   sts_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [2:0]  status_o,
  output logic [3:0]  result_lock_o,
  output logic [7:0]  target_tag_o,
  output logic        last_o
);

  localparam int unsigned LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = LW + QW;
  localparam int unsigned MEM_DEPTH = NUM_LOCKS << QW;

  logic [NUM_LOCKS-1:0] active_q, held_q;
  logic [6:0]           favor_q [NUM_LOCKS];
  logic [CW-1:0]        count_q [NUM_LOCKS];
  logic [23:0]          mem [MEM_DEPTH];
  logic [23:0]          rd_q;

  logic [1:0]  op_q;
  logic [3:0]  li_q;
  logic [7:0]  tag_q;
  logic [15:0] grp_q;
  logic [6:0]  fav_q;
  logic [LW-1:0] lk;

  logic [31:0] lcg_q;
  logic [7:0]  prod_q;  // low byte of the quotient estimate

  logic [CW-1:0] ptr_q;   // scan / shift pointer
  logic [CW-1:0] pick_q;
  logic [7:0]    head_q;

  logic [CW-1:0] cnt;
  logic [CW-1:0] ptr_m1;
  logic [LW-1:0] free_idx;
  logic          none_free;

  assign lk     = li_q[LW-1:0];
  assign cnt    = count_q[lk];
  assign ptr_m1 = ptr_q - CW'(1);

  always_comb begin
    none_free = 1'b1;
    free_idx  = '0;
    for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        none_free = 1'b0;
        free_idx  = LW'(i);
      end
    end
  end

  // draw = state mod 100: quotient estimate registered, then one correction
  logic [57:0] recip;
  logic [7:0]  rem, draw;
  assign recip = 58'(lcg_q) * 58'(RecipDiv100);
  assign rem   = lcg_q[7:0] - prod_q * DrawMod;
  assign draw  = (rem >= DrawMod) ? rem - DrawMod : rem;

  logic [AW-1:0] addr_base, rd_addr, wr_addr;
  logic [23:0]   wr_data;
  logic          wr_en;
  assign addr_base = AW'(lk) << QW;
  assign rd_addr   = addr_base | AW'(ptr_q[QW-1:0]);
  assign wr_en     = cmd_i.acq_queue || cmd_i.shift_step;
  assign wr_addr   = cmd_i.acq_queue ? (addr_base | AW'(cnt[QW-1:0]))
                                     : (addr_base | AW'(ptr_m1[QW-1:0]));
  assign wr_data   = cmd_i.acq_queue ? {grp_q, tag_q} : rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= op_i;
      li_q  <= lock_index_i;
      tag_q <= requester_tag_i;
      grp_q <= requester_group_i;
      fav_q <= favor_percent_i;
    end
    if (cmd_i.cre_do) favor_q[free_idx] <= fav_q;
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i.rd_issue) rd_q <= mem[rd_addr];
    if (cmd_i.lcg_mod) prod_q <= recip[39:32];
  end

  // lock state, generator, pointer and shift sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      held_q   <= '0;
      for (int i = 0; i < NUM_LOCKS; i++) count_q[i] <= '0;
      lcg_q    <= SeedRst;
      ptr_q    <= '0;
      pick_q   <= '0;
      head_q   <= '0;
    end else begin
      if (seed_we_i) lcg_q <= seed_i;
      else if (cmd_i.lcg_step) lcg_q <= lcg_q * LcgMul + LcgAdd;
      if (cmd_i.cre_do) begin
        active_q[free_idx] <= 1'b1;
        held_q[free_idx]   <= 1'b0;
        count_q[free_idx]  <= '0;
      end
      if (cmd_i.acq_grant) held_q[lk] <= 1'b1;
      if (cmd_i.acq_queue) count_q[lk] <= cnt + CW'(1);
      if (cmd_i.rel_clear) held_q[lk] <= 1'b0;
      if (cmd_i.des_do) begin
        active_q[lk] <= 1'b0;
        held_q[lk]   <= 1'b0;
        count_q[lk]  <= '0;
      end
      if (cmd_i.rel_finish) begin
        count_q[lk] <= cnt - CW'(1);
        held_q[lk]  <= 1'b1;
      end
      if (cmd_i.scan_init) begin
        ptr_q  <= '0;
        pick_q <= '0;
      end else if (cmd_i.shift_init) begin
        ptr_q <= pick_q;
      end else if (cmd_i.scan_step || cmd_i.shift_step) begin
        ptr_q <= ptr_q + CW'(1);
      end
      if (cmd_i.lcg_pick && draw < {1'b0, favor_q[lk]}) pick_q <= ptr_q;
      if (cmd_i.head_cap) head_q <= rd_q[7:0];
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.fav_bad    = fav_q > FavorMax;
  assign sts_o.none_free  = none_free;
  assign sts_o.idx_bad    = 32'(li_q) >= NUM_LOCKS;
  assign sts_o.active     = active_q[lk];
  assign sts_o.held       = held_q[lk];
  assign sts_o.q_empty    = cnt == '0;
  assign sts_o.q_full     = cnt >= CW'(QUEUE_DEPTH);
  assign sts_o.scan_end   = ptr_q >= cnt;
  assign sts_o.grp_hit    = rd_q[23:8] == grp_q;
  assign sts_o.out_busy   = out_valid_o && out_stall_i;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit_reply || cmd_i.emit_grant || cmd_i.emit_fail) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_reply) begin
      kind_o        <= KindReply;
      status_o      <= cmd_i.status;
      target_tag_o  <= tag_q;
      result_lock_o <= (op_q == OpCreate) ?
                       ((cmd_i.status == StOk) ? 4'(free_idx) : 4'd0) : li_q;
      last_o <= !((op_q == OpRelease && cmd_i.status == StOk && cnt != '0) ||
                  (op_q == OpDestroy && cmd_i.status == StOk && cnt != '0));
    end else if (cmd_i.emit_grant) begin
      kind_o        <= KindGrant;
      status_o      <= StOk;
      target_tag_o  <= head_q;
      result_lock_o <= li_q;
      last_o        <= 1'b1;
    end else if (cmd_i.emit_fail) begin
      kind_o        <= KindFail;
      status_o      <= StInactive;
      target_tag_o  <= rd_q[7:0];
      result_lock_o <= li_q;
      last_o        <= (ptr_q + CW'(1)) >= cnt;
    end
  end

endmodule

[rtl/galm_ctrl.sv]
module galm_ctrl import galm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  galm_sts_t sts_i,
  output galm_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SRD, S_SCHK, S_LCG, S_MOD, S_RSEL, S_HRD, S_HCAP,
    S_RRD, S_RSHIFT, S_GRANT, S_FRD, S_FEMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit_reply = 1'b1;
          cmd_o.scan_init  = 1'b1;
          state_d = S_IDLE;
          if (sts_i.op == OpCreate) begin
            if (sts_i.fav_bad) cmd_o.status = StBadArg;
            else if (sts_i.none_free) cmd_o.status = StFull;
            else begin
              cmd_o.status = StOk;
              cmd_o.cre_do = 1'b1;
            end
          end else if (sts_i.idx_bad) begin
            cmd_o.status = StBadArg;
          end else if (!sts_i.active) begin
            cmd_o.status = StInactive;
          end else begin
            case (sts_i.op)
              OpAcquire: begin
                if (!sts_i.held && sts_i.q_empty) begin
                  cmd_o.status = StOk;
                  cmd_o.acq_grant = 1'b1;
                end else if (sts_i.q_full) begin
                  cmd_o.status = StFull;
                end else begin
                  cmd_o.status = StQueued;
                  cmd_o.acq_queue = 1'b1;
                end
              end
              OpRelease: begin
                if (!sts_i.held) begin
                  cmd_o.status = StNotHeld;
                end else begin
                  cmd_o.status = StOk;
                  cmd_o.rel_clear = 1'b1;
                  if (!sts_i.q_empty) state_d = S_SRD;
                end
              end
              default: begin
                cmd_o.status = StOk;
                if (!sts_i.q_empty) state_d = S_FRD;
                else cmd_o.des_do = 1'b1;
              end
            endcase
          end
        end
      end
      S_SRD: begin
        // no group match leaves the head picked
        if (sts_i.scan_end) begin
          state_d = S_RSEL;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d = S_SCHK;
        end
      end
      S_SCHK: begin
        if (sts_i.grp_hit) begin
          cmd_o.lcg_step = 1'b1;
          state_d = S_LCG;
        end else begin
          cmd_o.scan_step = 1'b1;
          state_d = S_SRD;
        end
      end
      S_LCG: begin
        cmd_o.lcg_mod = 1'b1;
        state_d = S_MOD;
      end
      S_MOD: begin
        cmd_o.lcg_pick = 1'b1;
        state_d = S_RSEL;
      end
      S_RSEL: begin
        cmd_o.shift_init = 1'b1;
        state_d = S_HRD;
      end
      S_HRD: begin
        cmd_o.rd_issue = 1'b1;
        state_d = S_HCAP;
      end
      S_HCAP: begin
        cmd_o.head_cap  = 1'b1;
        cmd_o.scan_step = 1'b1;
        state_d = S_RRD;
      end
      S_RRD: begin
        if (sts_i.scan_end) begin
          state_d = S_GRANT;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d = S_RSHIFT;
        end
      end
      S_RSHIFT: begin
        cmd_o.shift_step = 1'b1;
        state_d = S_RRD;
      end
      S_GRANT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit_grant = 1'b1;
          cmd_o.rel_finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FRD: begin
        if (sts_i.scan_end) begin
          cmd_o.des_do = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d = S_FEMIT;
        end
      end
      S_FEMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit_fail = 1'b1;
          cmd_o.scan_step = 1'b1;
          state_d = S_FRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

[rtl/group_affinity_lock_manager.sv]
// channel | direction | handshake          | payload
// request | in        | in_valid_i/stall_o | op, lock_index, requester_tag/group, favor
// result  | out       | out_valid_o/stall_i| kind, status, result_lock, target_tag, last
// config  | in        | APB write          | random_seed at 0x0
// A request is accepted in S_IDLE, then decoded and replied to in S_DECODE.
// Release with waiters scans them until a group match, then draws against favor when one
// matches, fetches the granted entry, moves later entries down and emits the grant.
// Destroy with waiters emits a fail for each waiter, then deactivates the lock.
// Reset clears lock flags and counts; the generator and seed register return to SeedRst.
// A stalled result holds the sequencer until it is taken.
module group_affinity_lock_manager import galm_pkg::*; #(
  parameter int unsigned NUM_LOCKS   = NumLocksDefault,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [3:0]  lock_index_i,
  input  logic [7:0]  requester_tag_i,
  input  logic [15:0] requester_group_i,
  input  logic [6:0]  favor_percent_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [2:0]  status_o,
  output logic [3:0]  result_lock_o,
  output logic [7:0]  target_tag_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  galm_cmd_t cmd;
  galm_sts_t sts;
  logic [31:0] seed_q;
  logic        seed_we;

  assign pready  = 1'b1;
  assign seed_we = psel && penable && pwrite && (paddr == {RegSeed});
  assign prdata  = (paddr == {RegSeed}) ? seed_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seed_q <= SeedRst;
    else if (seed_we) seed_q <= pwdata;
  end

  galm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sts_i(sts), .cmd_o(cmd)
  );

  galm_datapath #(.NUM_LOCKS(NUM_LOCKS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk_i, .rst_ni, .op_i, .lock_index_i, .requester_tag_i, .requester_group_i,
    .favor_percent_i, .seed_we_i(seed_we), .seed_i(pwdata), .cmd_i(cmd),
    .sts_o(sts), .out_valid_o, .out_stall_i, .kind_o, .status_o,
    .result_lock_o, .target_tag_o, .last_o
  );

endmodule
